// ===== hdl/drle_pkg.sv =====
// ----------------------------------------------------------------------------
// drle_pkg
// Shared types and constants for the downsampling run-length pixel encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package drle_pkg;

    localparam int unsigned DIM_W          = 13;
    localparam int unsigned POS_W          = 12;
    localparam int unsigned PIX_W          = 32;
    localparam int unsigned CNT_W          = 16;
    localparam int unsigned SLOT_W         = 3;
    localparam int unsigned TOTAL_W        = 23;
    localparam int unsigned CFG_IDX_W      = 2;

    localparam logic [DIM_W-1:0]  MAX_DIM        = 13'd4096;
    localparam logic [SLOT_W-1:0] LAST_SLOT      = 3'd7;
    localparam logic [CNT_W-1:0]  RUN_CAP        = 16'hFFFF;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH = 2'd2;

    // Reset values of the registers
    localparam logic [DIM_W-1:0] RST_SRC_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0] RST_SRC_HEIGHT = 13'd1136;
    localparam logic [DIM_W-1:0] RST_LINE_PITCH = 13'd640;

    // Effective frame geometry, already saturated
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] pitch;
    } t_dims;

    // One result beat
    typedef struct packed {
        logic [CNT_W-1:0]   run_count;
        logic [PIX_W-1:0]   run_pixel;
        logic [SLOT_W-1:0]  slot_number;
        logic               line_done;
        logic               is_padding;
        logic               frame_done;
        logic [TOTAL_W-1:0] pair_total;
    } t_result;

    // Saturate a dimension into 1..MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = {{(DIM_W-1){1'b0}}, 1'b1};
        end else if (v > MAX_DIM) begin
            r = MAX_DIM;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/drle_pix_if.sv =====
// ----------------------------------------------------------------------------
// drle_pix_if
// Pixel input channel: valid/ready handshake with one 32-bit pixel per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface drle_pix_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/drle_res_if.sv =====
// ----------------------------------------------------------------------------
// drle_res_if
// Result channel: valid/ready handshake carrying one run pair or closing beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface drle_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] run_count;
    logic [31:0] run_pixel;
    logic [2:0]  slot_number;
    logic        line_done;
    logic        is_padding;
    logic        frame_done;
    logic [22:0] pair_total;

    modport source (
        output valid, output run_count, output run_pixel, output slot_number,
        output line_done, output is_padding, output frame_done, output pair_total,
        input  ready
    );
    modport sink (
        input  valid, input run_count, input run_pixel, input slot_number,
        input  line_done, input is_padding, input frame_done, input pair_total,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/downsample_rle_pixel_encoder.sv =====
// ----------------------------------------------------------------------------
// downsample_rle_pixel_encoder
// Downsamples a 32-bit raster by two in each direction and run-length encodes
// the kept pixels into (count, pixel) pairs, eight pairs to a line.
// ----------------------------------------------------------------------------
// The encoder takes one source pixel per clock while the result side keeps
// up; a pixel that closes a run hands its pair to the output register in the
// same cycle it is taken, and the pair is presented once any beat ahead of it
// has been taken. At the last pixel of a frame the input is held off while
// the flush sequencer drains the frame: the pair of the open run, if any,
// padding pairs (up to seven) to fill the line, a step to leave padding and
// then the closing beat. Results pass through a two-entry output register, so
// the pixel side keeps moving while a finished beat waits to be taken.
// Register writes take effect on the next pixel and are meant for idle periods.
`default_nettype none

module downsample_rle_pixel_encoder (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [drle_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [drle_pkg::DIM_W-1:0]     i_cfg_data,
    drle_pix_if.sink                            i_pix,
    drle_res_if.source                          o_res
);
    import drle_pkg::*;

    t_dims   dims;
    logic    core_valid;
    logic    core_ready;
    t_result core_res;
    t_result out_res;

    drle_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_dims     (dims)
    );

    drle_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dims      (dims),
        .i_pix       (i_pix),
        .o_res_valid (core_valid),
        .i_res_ready (core_ready),
        .o_res       (core_res)
    );

    drle_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (core_valid),
        .o_ready (core_ready),
        .i_data  (core_res),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_data  (out_res)
    );

    // Spread the result beat onto the channel
    assign o_res.run_count   = out_res.run_count;
    assign o_res.run_pixel   = out_res.run_pixel;
    assign o_res.slot_number = out_res.slot_number;
    assign o_res.line_done   = out_res.line_done;
    assign o_res.is_padding  = out_res.is_padding;
    assign o_res.frame_done  = out_res.frame_done;
    assign o_res.pair_total  = out_res.pair_total;

endmodule

`default_nettype wire

// ===== hdl/drle_cfg.sv =====
// ----------------------------------------------------------------------------
// drle_cfg
// Configuration registers. Dimensions are saturated as they are written, and
// the effective pitch is never below the effective width.
// ----------------------------------------------------------------------------
`default_nettype none

module drle_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [drle_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [drle_pkg::DIM_W-1:0]    i_cfg_data,
    output drle_pkg::t_dims                    o_dims
);
    import drle_pkg::*;

    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [DIM_W-1:0] r_pitch;

    // Decode the register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_SRC_WIDTH;
            r_height <= RST_SRC_HEIGHT;
            r_pitch  <= RST_LINE_PITCH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SRC_WIDTH:  r_width  <= clamp_dim(i_cfg_data);
                CFG_SRC_HEIGHT: r_height <= clamp_dim(i_cfg_data);
                CFG_LINE_PITCH: r_pitch  <= clamp_dim(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Widen a short pitch to the visible width
    always_comb begin
        o_dims.width  = r_width;
        o_dims.height = r_height;
        o_dims.pitch  = (r_pitch < r_width) ? r_width : r_pitch;
    end

endmodule

`default_nettype wire

// ===== hdl/drle_core.sv =====
// ----------------------------------------------------------------------------
// drle_core
// Raster position tracking, run building and frame-end flush sequencer.
// Emits at most one result beat per cycle toward the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module drle_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire drle_pkg::t_dims i_dims,
    drle_pix_if.sink        i_pix,
    output logic            o_res_valid,
    input  wire logic       i_res_ready,
    output drle_pkg::t_result o_res
);
    import drle_pkg::*;

    typedef enum logic [3:0] {
        ST_RUN   = 4'b0001,
        ST_LAST  = 4'b0010,
        ST_PAD   = 4'b0100,
        ST_CLOSE = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [POS_W-1:0]     r_col, n_col;
    logic [POS_W-1:0]     r_row, n_row;
    logic [PIX_W-1:0]     r_held, n_held;
    logic [CNT_W-1:0]     r_run, n_run;
    logic [SLOT_W-1:0]    r_slot, n_slot;
    logic [TOTAL_W-1:0]   r_pairs, n_pairs;

    logic                 pix_fire;
    logic                 res_fire;
    logic                 kept;
    logic                 extend;
    logic                 col_end;
    logic                 row_end;
    logic                 slot_last;
    logic [DIM_W-1:0]     kept_cols;
    logic [DIM_W-1:0]     kept_rows;
    logic [DIM_W-1:0]     col_inc;
    logic [DIM_W-1:0]     row_inc;

    // Classify the current raster position
    always_comb begin
        kept_cols = {i_dims.width[DIM_W-1:1], 1'b0};
        kept_rows = {i_dims.height[DIM_W-1:1], 1'b0};
        col_inc   = {1'b0, r_col} + 13'd1;
        row_inc   = {1'b0, r_row} + 13'd1;
        col_end   = col_inc >= i_dims.pitch;
        row_end   = row_inc >= i_dims.height;
        kept      = !r_col[0] && ({1'b0, r_col} < kept_cols) &&
                    !r_row[0] && ({1'b0, r_row} < kept_rows);
        extend    = (r_run != '0) && (i_pix.pixel_value == r_held) && (r_run < RUN_CAP);
        slot_last = r_slot == LAST_SLOT;
    end

    assign i_pix.ready = (r_state == ST_RUN) && i_res_ready;
    assign pix_fire    = i_pix.valid && i_pix.ready;
    assign res_fire    = o_res_valid && i_res_ready;

    // Select the result beat for this cycle
    always_comb begin
        o_res_valid       = 1'b0;
        o_res.run_count   = r_run;
        o_res.run_pixel   = r_held;
        o_res.slot_number = r_slot;
        o_res.line_done   = slot_last;
        o_res.is_padding  = 1'b0;
        o_res.frame_done  = 1'b0;
        o_res.pair_total  = '0;
        unique case (r_state)
            ST_RUN:   o_res_valid = pix_fire && kept && !extend && (r_run != '0);
            ST_LAST:  o_res_valid = r_run != '0;
            ST_PAD: begin
                o_res_valid      = r_slot != '0;
                o_res.run_count  = '0;
                o_res.run_pixel  = '0;
                o_res.is_padding = 1'b1;
            end
            ST_CLOSE: begin
                o_res_valid       = 1'b1;
                o_res.run_count   = '0;
                o_res.run_pixel   = '0;
                o_res.slot_number = '0;
                o_res.line_done   = 1'b0;
                o_res.frame_done  = 1'b1;
                o_res.pair_total  = r_pairs;
            end
            default: o_res_valid = 1'b0;
        endcase
    end

    // Advance position, run and flush state
    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_row   = r_row;
        n_held  = r_held;
        n_run   = r_run;
        n_slot  = r_slot;
        n_pairs = r_pairs;

        // Place a pair into the next slot
        if (res_fire && !o_res.frame_done) begin
            n_slot = slot_last ? '0 : r_slot + 3'd1;
            if (!o_res.is_padding) begin
                n_pairs = r_pairs + 23'd1;
            end
        end

        unique case (r_state)
            ST_RUN: begin
                if (pix_fire) begin
                    if (kept) begin
                        if (extend) begin
                            n_run = r_run + 16'd1;
                        end else begin
                            n_held = i_pix.pixel_value;
                            n_run  = 16'd1;
                        end
                    end
                    if (col_end) begin
                        n_col = '0;
                        if (row_end) begin
                            n_row   = '0;
                            n_state = ST_LAST;
                        end else begin
                            n_row = row_inc[POS_W-1:0];
                        end
                    end else begin
                        n_col = col_inc[POS_W-1:0];
                    end
                end
            end
            ST_LAST: begin
                if (r_run == '0 || res_fire) begin
                    n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                if (r_slot == '0) begin
                    n_state = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                if (res_fire) begin
                    n_run   = '0;
                    n_slot  = '0;
                    n_pairs = '0;
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_col   <= '0;
            r_row   <= '0;
            r_run   <= '0;
            r_slot  <= '0;
            r_pairs <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_run   <= n_run;
            r_slot  <= n_slot;
            r_pairs <= n_pairs;
        end
    end

    // Held pixel is qualified by a nonzero run length
    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

    a_no_pixel_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RUN) |-> !i_pix.ready)
        else $error("pixel channel open during frame flush");

    a_close_on_line_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLOSE) |-> (r_slot == '0))
        else $error("closing beat not on a line boundary");

    a_close_clears_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_fire && o_res.frame_done) |=>
            (r_state == ST_RUN) && (r_run == '0) && (r_pairs == '0))
        else $error("frame state not cleared after closing beat");

    a_pad_only_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.is_padding) |-> (r_state == ST_PAD) && (r_run == '0 ||
            r_state == ST_PAD))
        else $error("padding pair outside frame flush");

    a_frame_end_enters_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pix_fire && col_end && row_end) |=> (r_state == ST_LAST))
        else $error("frame end did not start the flush");

endmodule

`default_nettype wire

// ===== hdl/drle_out_stage.sv =====
// ----------------------------------------------------------------------------
// drle_out_stage
// Two-entry output register with skid slot; ready toward the core is
// registered so the core never stalls on a combinational path from the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module drle_out_stage (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire drle_pkg::t_result i_data,
    output logic              o_valid,
    input  wire logic         i_ready,
    output drle_pkg::t_result o_data
);
    import drle_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    in_fire;
    logic    main_free;

    assign o_ready   = !r_skid_valid;
    assign o_valid   = r_main_valid;
    assign o_data    = r_main;
    assign in_fire   = i_valid && o_ready;
    assign main_free = !r_main_valid || i_ready;

    // Track occupancy of both entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (main_free) begin
            r_main_valid <= r_skid_valid || in_fire;
            r_skid_valid <= 1'b0;
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Move beats: skid drains first, then fresh input
    always_ff @(posedge i_clk) begin
        if (main_free) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (in_fire) begin
            r_skid <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the downsampling run-length pixel encoder.
// A class tracks raster position, open run and line slot, and predicts every
// pair, padding beat and closing beat as each pixel beat is taken. Directed
// frames cover the corner cases. Random frames follow with small geometries
// and bursts of idling on both channels. A final stretch then runs with no
// idling.
// ----------------------------------------------------------------------------

class run_pair_checker;
    bit [12:0] width_reg;
    bit [12:0] height_reg;
    bit [12:0] pitch_reg;
    bit [11:0] col_pos;
    bit [11:0] row_pos;
    bit [31:0] held_pixel;
    bit [15:0] run_len;
    bit [2:0]  slot_idx;
    bit [22:0] real_pairs;
    drle_pkg::t_result expected_pairs[$];
    int unsigned failures;

    function new();
        width_reg  = drle_pkg::RST_SRC_WIDTH;
        height_reg = drle_pkg::RST_SRC_HEIGHT;
        pitch_reg  = drle_pkg::RST_LINE_PITCH;
        col_pos    = '0;
        row_pos    = '0;
        held_pixel = '0;
        run_len    = '0;
        slot_idx   = '0;
        real_pairs = '0;
        failures   = 0;
    endfunction

    function void write_register(bit [drle_pkg::CFG_IDX_W-1:0] idx, bit [12:0] value);
        case (idx)
            drle_pkg::CFG_SRC_WIDTH: begin
                width_reg = value;
            end
            drle_pkg::CFG_SRC_HEIGHT: begin
                height_reg = value;
            end
            drle_pkg::CFG_LINE_PITCH: begin
                pitch_reg = value;
            end
            default: begin
            end
        endcase
    endfunction

    // Saturate a dimension into 1..MAX_DIM
    function int unsigned dim_of(bit [12:0] v);
        if (v == 0) return 1;
        if (v > drle_pkg::MAX_DIM) return drle_pkg::MAX_DIM;
        return v;
    endfunction

    // Put one pair into the next slot of the line
    function void place_pair(bit [15:0] cnt, bit [31:0] pix, bit pad);
        drle_pkg::t_result r;
        r = '0;
        r.run_count   = cnt;
        r.run_pixel   = pix;
        r.slot_number = slot_idx;
        r.line_done   = (slot_idx == drle_pkg::LAST_SLOT);
        r.is_padding  = pad;
        expected_pairs.push_back(r);
        slot_idx = slot_idx + 3'd1;
        if (!pad) real_pairs = real_pairs + 23'd1;
    endfunction

    // Advance the encoder by one source pixel
    function void take_pixel(bit [31:0] pix);
        int unsigned w;
        int unsigned h;
        int unsigned p;
        int unsigned kept_cols;
        int unsigned kept_rows;
        drle_pkg::t_result closing;
        w = dim_of(width_reg);
        h = dim_of(height_reg);
        p = dim_of(pitch_reg);
        if (p < w) p = w;
        kept_cols = (w / 2) * 2;
        kept_rows = (h / 2) * 2;

        // extend or restart the run on a kept pixel
        if (!col_pos[0] && col_pos < kept_cols && !row_pos[0] && row_pos < kept_rows) begin
            if (run_len != 0 && pix == held_pixel && run_len != drle_pkg::RUN_CAP) begin
                run_len = run_len + 16'd1;
            end else begin
                if (run_len != 0) place_pair(run_len, held_pixel, 1'b0);
                held_pixel = pix;
                run_len    = 16'd1;
            end
        end

        // step the raster; flush at the last pixel of the frame
        if (col_pos + 1 >= p) begin
            col_pos = '0;
            if (row_pos + 1 >= h) begin
                if (run_len != 0) place_pair(run_len, held_pixel, 1'b0);
                while (slot_idx != 0) place_pair(16'd0, 32'd0, 1'b1);
                closing = '0;
                closing.frame_done = 1'b1;
                closing.pair_total = real_pairs;
                expected_pairs.push_back(closing);
                row_pos    = '0;
                held_pixel = '0;
                run_len    = '0;
                slot_idx   = '0;
                real_pairs = '0;
            end else begin
                row_pos = row_pos + 12'd1;
            end
        end else begin
            col_pos = col_pos + 12'd1;
        end
    endfunction

    function int unsigned pending();
        return expected_pairs.size();
    endfunction

    // Compare a result beat against the oldest prediction
    function void check_pair(drle_pkg::t_result got);
        drle_pkg::t_result want;
        if (expected_pairs.size() == 0) begin
            failures++;
            if (failures <= 10) begin
                $display("%0t: unexpected result beat: count %0d pixel %h frame_done %b",
                         $time, got.run_count, got.run_pixel, got.frame_done);
            end
            return;
        end
        want = expected_pairs.pop_front();
        if (got.run_count !== want.run_count || got.run_pixel !== want.run_pixel ||
            got.slot_number !== want.slot_number || got.line_done !== want.line_done ||
            got.is_padding !== want.is_padding || got.frame_done !== want.frame_done ||
            got.pair_total !== want.pair_total) begin
            failures++;
            if (failures <= 10) begin
                $display("%0t: result mismatch (exp/got): count %0d/%0d pixel %h/%h",
                         $time, want.run_count, got.run_count, want.run_pixel,
                         got.run_pixel);
                $display("    slot %0d/%0d line %b/%b pad %b/%b frame %b/%b total %0d/%0d",
                         want.slot_number, got.slot_number, want.line_done, got.line_done,
                         want.is_padding, got.is_padding, want.frame_done, got.frame_done,
                         want.pair_total, got.pair_total);
            end
        end
    endfunction
endclass

module tb;
    import drle_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_500_000;
    localparam int unsigned FLUSH_CYCLES = 16;
    localparam int unsigned RANDOM_ITEMS = 480;
    localparam int unsigned QUIET_ITEMS  = 60;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DIM_W-1:0]     cfg_data;

    drle_pix_if pix_if ();
    drle_res_if res_if ();

    run_pair_checker board;
    bit              sink_stalls;
    bit              src_gaps;
    int unsigned     cycle_count = 0;
    bit [31:0]       palette[4];
    bit [31:0]       last_pix;

    downsample_rle_pixel_encoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if),
        .o_res      (res_if)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Predict on every pixel beat, then check every result beat
    always @(posedge i_clk) begin : monitor
        t_result beat;
        if (i_rst_n) begin
            if (pix_if.valid && pix_if.ready) board.take_pixel(pix_if.pixel_value);
            if (res_if.valid && res_if.ready) begin
                beat.run_count   = res_if.run_count;
                beat.run_pixel   = res_if.run_pixel;
                beat.slot_number = res_if.slot_number;
                beat.line_done   = res_if.line_done;
                beat.is_padding  = res_if.is_padding;
                beat.frame_done  = res_if.frame_done;
                beat.pair_total  = res_if.pair_total;
                board.check_pair(beat);
            end
        end
    end

    // Result side: stall in random bursts while allowed
    initial begin : sink_ctrl
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
                if (sink_stalls && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 9);
            end
        end
    end

    // Present one pixel and hold it until taken
    task automatic send_pixel(input logic [31:0] value);
        @(negedge i_clk);
        pix_if.valid       <= 1'b1;
        pix_if.pixel_value <= value;
        do @(posedge i_clk); while (!pix_if.ready);
    endtask

    // Drop valid, then idle the source for the span given by n
    task automatic hold_input(input int unsigned n);
        @(negedge i_clk);
        pix_if.valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Stop sending and wait out every predicted beat
    task automatic drain();
        hold_input(1);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (FLUSH_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        board.write_register(idx, value);
    endtask

    // Reprogram all three dimensions while idle
    task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                input logic [DIM_W-1:0] p);
        drain();
        write_reg(CFG_SRC_WIDTH, w);
        write_reg(CFG_SRC_HEIGHT, h);
        write_reg(CFG_LINE_PITCH, p);
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly small dimensions, now and then a saturating extreme
    function automatic logic [DIM_W-1:0] pick_dim(input int unsigned hi);
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        if (roll == 2) return MAX_DIM;
        return DIM_W'($urandom_range(1, hi));
    endfunction

    // Favor repeats so that runs form
    function automatic logic [31:0] pick_pixel();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 5) return last_pix;
        if (roll < 8) return palette[$urandom_range(0, 3)];
        return $urandom();
    endfunction

    task automatic random_frames(input int unsigned quota);
        int unsigned sent;
        int unsigned n;
        int unsigned phase;
        bit          pause;
        sent  = 0;
        phase = 0;
        while (sent < quota) begin
            set_geometry(pick_dim(12), pick_dim(6), pick_dim(14));
            foreach (palette[k]) palette[k] = $urandom();
            n     = $urandom_range(8, 48);
            pause = (quota > QUIET_ITEMS) && ((phase == 1) || ($urandom_range(0, 5) == 0));
            if (quota > QUIET_ITEMS) begin
                sink_stalls = ($urandom_range(0, 3) != 0);
                src_gaps    = ($urandom_range(0, 3) != 0);
            end
            for (int unsigned i = 0; i < n; i++) begin
                if (src_gaps && $urandom_range(0, 5) == 0) hold_input($urandom_range(1, 9));
                // let the result side catch up completely once in a while
                if (pause && i == n / 2) begin
                    hold_input(1);
                    while (board.pending() != 0) @(posedge i_clk);
                end
                last_pix = pick_pixel();
                send_pixel(last_pix);
            end
            sent += n;
            phase++;
        end
    endtask

    initial begin
        board              = new();
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = CFG_SRC_WIDTH;
        cfg_data           = '0;
        pix_if.valid       = 1'b0;
        pix_if.pixel_value = '0;
        res_if.ready       = 1'b0;
        sink_stalls        = 1'b0;
        src_gaps           = 1'b0;
        last_pix           = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero first pixel still opens a run; one run then padding to a full line
        set_geometry(13'd4, 13'd2, 13'd0);
        send_pixel(32'h0000_0000);
        send_pixel(32'h1234_5678);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0000);
        send_pixel(32'h8000_0000);
        send_pixel(32'h7FFF_FFFF);

        // nothing kept: only closing beats
        set_geometry(13'd1, 13'd1, 13'd1);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0000);

        // eight distinct runs fill the line exactly; height drops before the last pixel
        set_geometry(13'd16, 13'd2, 13'd16);
        for (int unsigned i = 0; i < 15; i++) send_pixel(i * 32'h1111_1111);
        set_geometry(13'd16, 13'd1, 13'd16);
        send_pixel(32'hA5A5_A5A5);

        random_frames(RANDOM_ITEMS - QUIET_ITEMS);

        // close the open frame, then finish with no idling
        sink_stalls = 1'b0;
        src_gaps    = 1'b0;
        set_geometry(13'd1, 13'd1, 13'd1);
        send_pixel($urandom());

        random_frames(QUIET_ITEMS);

        drain();
        if (board.failures == 0 && board.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
